// ----- rtl/macroblock_neighbour_locator_top_macros.svh -----
// assertion macros for the neighbour locator
`ifndef MACROBLOCK_NEIGHBOUR_LOCATOR_TOP_MACROS_SVH
`define MACROBLOCK_NEIGHBOUR_LOCATOR_TOP_MACROS_SVH

// checked only out of reset
`define NBL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NBL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/nbl_pkg.sv -----
`default_nettype none
package nbl_pkg;

	localparam int MAX_WIDTH_MBS_DEF = 512;
	localparam int MAX_PIC_MBS_DEF   = 65536;

	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PIC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIC_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MBAFF     = 2'd2;

	localparam logic [1:0] DBK_DECODE     = 2'd0;
	localparam logic [1:0] DBK_FILTER     = 2'd1;
	localparam logic [1:0] DBK_FILTER_TOP = 2'd2;

	localparam int NB_A = 0;
	localparam int NB_B = 1;
	localparam int NB_C = 2;
	localparam int NB_D = 3;

	localparam int IDX_W = 18;

	typedef struct packed {
		logic [15:0] cur_mb_index;
		logic [5:0]  x_offset;
		logic [5:0]  y_offset;
		logic [2:0]  block_width_log2;
		logic [2:0]  block_height_log2;
		logic        cur_is_field;
		logic [1:0]  deblock_mode;
		logic [3:0]  neighbour_same_slice;
		logic [3:0]  neighbour_field;
	} in_item_t;

	typedef struct packed {
		logic        sel;
		logic        av;
		logic [16:0] idx;
		logic        show;
		logic        in_pic;
		logic        idx_lsb;
		logic [6:0]  xin;
		logic [6:0]  yin;
		logic [2:0]  lw;
		logic [2:0]  lh;
	} mid_item_t;

endpackage
`default_nettype wire

// ----- rtl/nbl_if.sv -----
`default_nettype none
interface nbl_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] cur_mb_index;
	logic signed [5:0] x_offset;
	logic signed [5:0] y_offset;
	logic [2:0]  block_width_log2;
	logic [2:0]  block_height_log2;
	logic        cur_is_field;
	logic [1:0]  deblock_mode;
	logic [3:0]  neighbour_same_slice;
	logic [3:0]  neighbour_field;

	modport source(output valid, cur_mb_index, x_offset, y_offset, block_width_log2,
		block_height_log2, cur_is_field, deblock_mode, neighbour_same_slice,
		neighbour_field, input ready);
	modport sink(input valid, cur_mb_index, x_offset, y_offset, block_width_log2,
		block_height_log2, cur_is_field, deblock_mode, neighbour_same_slice,
		neighbour_field, output ready);
endinterface

interface nbl_out_if;
	logic        valid;
	logic        ready;
	logic signed [16:0] nb_mb_index;
	logic        nb_available;
	logic [3:0]  x_in_mb;
	logic [3:0]  y_in_mb;
	logic [12:0] pos_x;
	logic [12:0] pos_y;

	modport source(output valid, nb_mb_index, nb_available, x_in_mb, y_in_mb, pos_x, pos_y,
		input ready);
	modport sink(input valid, nb_mb_index, nb_available, x_in_mb, y_in_mb, pos_x, pos_y,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/nbl_div.sv -----
`default_nettype none
module nbl_div #(
	parameter int NW = 16,
	parameter int DW = 10,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [PW-1:0] pay_in,
	output logic               out_valid,
	output logic [NW-1:0]      quot,
	output logic [DW-1:0]      rem,
	output logic [PW-1:0]      pay_out
);

	logic [DW-1:0] rem_w [0:NW];
	logic [NW-1:0] num_w [0:NW];
	logic [NW-1:0] quo_w [0:NW];
	logic [PW-1:0] pay_w [0:NW];
	logic          vld_w [0:NW];

	assign rem_w[0] = '0;
	assign num_w[0] = dividend;
	assign quo_w[0] = '0;
	assign pay_w[0] = pay_in;
	assign vld_w[0] = in_valid;

	// one quotient bit per stage
	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DW:0]   trial;
		logic          fit;
		logic [DW-1:0] rem_s;
		logic [NW-1:0] num_s;
		logic [NW-1:0] quo_s;
		logic [PW-1:0] pay_s;
		logic          vld_s;

		assign trial = {rem_w[i], num_w[i][NW-1]};
		assign fit   = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (en) begin
				vld_s <= vld_w[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= fit ? DW'(trial - {1'b0, divisor}) : DW'(trial);
				num_s <= num_w[i] << 1;
				quo_s <= NW'({quo_w[i], fit});
				pay_s <= pay_w[i];
			end
		end

		assign rem_w[i+1] = rem_s;
		assign num_w[i+1] = num_s;
		assign quo_w[i+1] = quo_s;
		assign pay_w[i+1] = pay_s;
		assign vld_w[i+1] = vld_s;
	end

	assign out_valid = vld_w[NW];
	assign quot      = quo_w[NW];
	assign rem       = rem_w[NW];
	assign pay_out   = pay_w[NW];

endmodule
`default_nettype wire

// ----- rtl/macroblock_neighbour_locator_top.sv -----
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | request: current mb, offset, sizes, flags
// out_ch   | out | valid / ready | neighbour index, availability, coordinates
// wr_*     | in  | wr_en         | register index and data, no read-back
// one item enters per cycle while out_ch is not stalled; 35 register stages (two 16-stage dividers
// by the picture width plus three logic stages)
// the dividers set the latency, one quotient bit per stage
// arst_n clears valid bits and registers; payload is not reset
// out_ch stall freezes the whole pipeline; ready follows the output register
`default_nettype none
module macroblock_neighbour_locator_top #(
	parameter int MAX_WIDTH_MBS = nbl_pkg::MAX_WIDTH_MBS_DEF,
	parameter int MAX_PIC_MBS   = nbl_pkg::MAX_PIC_MBS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [nbl_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [nbl_pkg::CFG_DATA_W-1:0] wr_data,
	nbl_in_if.sink                             in_ch,
	nbl_out_if.source                          out_ch
);

	localparam int DW = $clog2(MAX_WIDTH_MBS + 1);
	localparam int SW = $clog2(MAX_PIC_MBS + 1);
	localparam int CW = ((SW > 17) ? SW : 17) + 1;
	localparam int IW = nbl_pkg::IDX_W;

	// configuration
	logic [DW-1:0] w_q;
	logic [SW-1:0] s_q;
	logic          mbaff_q;
	logic [9:0]    w_raw;
	logic [16:0]   s_raw;

	assign w_raw = wr_data[9:0];
	assign s_raw = wr_data[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= DW'(1);
			s_q     <= SW'(1);
			mbaff_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == nbl_pkg::REG_PIC_WIDTH) begin
				if (w_raw == '0) begin
					w_q <= DW'(1);
				end else if (32'(w_raw) > 32'(MAX_WIDTH_MBS)) begin
					w_q <= DW'(MAX_WIDTH_MBS);
				end else begin
					w_q <= DW'(w_raw);
				end
			end
			if (wr_index == nbl_pkg::REG_PIC_SIZE) begin
				if (32'(s_raw) > 32'(MAX_PIC_MBS)) begin
					s_q <= SW'(MAX_PIC_MBS);
				end else begin
					s_q <= SW'(s_raw);
				end
			end
			if (wr_index == nbl_pkg::REG_MBAFF) begin
				mbaff_q <= wr_data[0];
			end
		end
	end

	logic en;
	logic out_valid_q;

	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// column of the current mb or pair
	nbl_pkg::in_item_t in_item;
	logic [15:0]       d1_num;
	logic              d1_valid;
	logic [15:0]       d1_quot;
	logic [DW-1:0]     d1_rem;
	logic [$bits(nbl_pkg::in_item_t)-1:0] d1_pay;
	nbl_pkg::in_item_t d1_item;

	assign in_item.cur_mb_index         = in_ch.cur_mb_index;
	assign in_item.x_offset             = in_ch.x_offset;
	assign in_item.y_offset             = in_ch.y_offset;
	assign in_item.block_width_log2     = in_ch.block_width_log2;
	assign in_item.block_height_log2    = in_ch.block_height_log2;
	assign in_item.cur_is_field         = in_ch.cur_is_field;
	assign in_item.deblock_mode         = in_ch.deblock_mode;
	assign in_item.neighbour_same_slice = in_ch.neighbour_same_slice;
	assign in_item.neighbour_field      = in_ch.neighbour_field;

	assign d1_num = mbaff_q ? {1'b0, in_ch.cur_mb_index[15:1]} : in_ch.cur_mb_index;

	nbl_div #(.NW(16), .DW(DW), .PW($bits(nbl_pkg::in_item_t))) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.dividend (d1_num),
		.divisor  (w_q),
		.pay_in   (in_item),
		.out_valid(d1_valid),
		.quot     (d1_quot),
		.rem      (d1_rem),
		.pay_out  (d1_pay)
	);

	assign d1_item = nbl_pkg::in_item_t'(d1_pay);

	// neighbour indices and availability
	logic signed [IW-1:0] nb_c [4];
	logic [3:0]           av4_c;
	logic signed [IW-1:0] cur_e, pair_e, w_e;
	logic                 col_nz, next_nz;

	always_comb begin
		cur_e   = signed'(IW'(d1_item.cur_mb_index));
		pair_e  = signed'(IW'(d1_item.cur_mb_index[15:1]));
		w_e     = signed'(IW'(w_q));
		col_nz  = d1_rem != '0;
		next_nz = ({1'b0, d1_rem} + (DW+1)'(1)) != {1'b0, w_q};
		if (mbaff_q) begin
			nb_c[nbl_pkg::NB_A] = (pair_e - IW'(1)) <<< 1;
			nb_c[nbl_pkg::NB_B] = (pair_e - w_e) <<< 1;
			nb_c[nbl_pkg::NB_C] = (pair_e - w_e + IW'(1)) <<< 1;
			nb_c[nbl_pkg::NB_D] = (pair_e - w_e - IW'(1)) <<< 1;
		end else begin
			nb_c[nbl_pkg::NB_A] = cur_e - IW'(1);
			nb_c[nbl_pkg::NB_D] = cur_e - IW'(1) - w_e;
			nb_c[nbl_pkg::NB_B] = cur_e - w_e;
			nb_c[nbl_pkg::NB_C] = cur_e - w_e + IW'(1);
		end
		for (int k = 0; k < 4; k++) begin
			av4_c[k] = !nb_c[k][IW-1] && (CW'(nb_c[k][IW-2:0]) < CW'(s_q))
				&& (d1_item.deblock_mode != nbl_pkg::DBK_DECODE
				|| d1_item.neighbour_same_slice[k]);
		end
		av4_c[nbl_pkg::NB_A] = av4_c[nbl_pkg::NB_A] && col_nz;
		av4_c[nbl_pkg::NB_D] = av4_c[nbl_pkg::NB_D] && col_nz;
		av4_c[nbl_pkg::NB_C] = av4_c[nbl_pkg::NB_C] && next_nz;
	end

	logic                 vld_s1;
	nbl_pkg::in_item_t    item_s1;
	logic signed [IW-1:0] nb_s1 [4];
	logic [3:0]           av4_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= d1_item;
			nb_s1   <= nb_c;
			av4_s1  <= av4_c;
		end
	end

	// neighbour selection
	logic                 sel_c, av_c, top, fld, dbk1, dbk2;
	logic signed [IW-1:0] idx_c, cur1;
	logic signed [9:0]    xs, ys, mw, mh, ym_c;
	logic [3:0]           fl;

	always_comb begin
		cur1 = signed'(IW'(item_s1.cur_mb_index));
		xs   = 10'(signed'(item_s1.x_offset));
		ys   = 10'(signed'(item_s1.y_offset));
		mw   = signed'(10'd1 << item_s1.block_width_log2);
		mh   = signed'(10'd1 << item_s1.block_height_log2);
		top  = !item_s1.cur_mb_index[0];
		fld  = item_s1.cur_is_field;
		fl   = item_s1.neighbour_field;
		dbk1 = item_s1.deblock_mode == nbl_pkg::DBK_FILTER;
		dbk2 = item_s1.deblock_mode == nbl_pkg::DBK_FILTER_TOP;
		sel_c = 1'b0;
		av_c  = 1'b0;
		idx_c = '0;
		ym_c  = -10'sd1;
		if (!mbaff_q) begin
			ym_c = ys;
			if (xs < 0) begin
				if (ys < 0) begin
					sel_c = 1'b1; idx_c = nb_s1[nbl_pkg::NB_D]; av_c = av4_s1[nbl_pkg::NB_D];
				end else if (ys < mh) begin
					sel_c = 1'b1; idx_c = nb_s1[nbl_pkg::NB_A]; av_c = av4_s1[nbl_pkg::NB_A];
				end
			end else if (xs < mw) begin
				if (ys < 0) begin
					sel_c = 1'b1; idx_c = nb_s1[nbl_pkg::NB_B]; av_c = av4_s1[nbl_pkg::NB_B];
				end else if (ys < mh) begin
					sel_c = 1'b1; idx_c = cur1; av_c = 1'b1;
				end
			end else if (ys < 0) begin
				sel_c = 1'b1; idx_c = nb_s1[nbl_pkg::NB_C]; av_c = av4_s1[nbl_pkg::NB_C];
			end
		end else if (ys <= mh - 10'sd1 && !(xs > mw - 10'sd1 && ys >= 0)) begin
			sel_c = 1'b1;
			if (xs < 0) begin
				if (ys < 0) begin
					if (!fld) begin
						if (top) begin
							idx_c = nb_s1[nbl_pkg::NB_D] + IW'(1);
							av_c  = av4_s1[nbl_pkg::NB_D];
							ym_c  = ys;
						end else begin
							idx_c = nb_s1[nbl_pkg::NB_A];
							av_c  = av4_s1[nbl_pkg::NB_A];
							if (av_c) begin
								if (!fl[nbl_pkg::NB_A]) begin
									ym_c = ys;
								end else begin
									idx_c = idx_c + IW'(1);
									ym_c  = (ys + mh) >>> 1;
								end
							end
						end
					end else if (top) begin
						idx_c = nb_s1[nbl_pkg::NB_D];
						av_c  = av4_s1[nbl_pkg::NB_D];
						if (av_c) begin
							if (!fl[nbl_pkg::NB_D]) begin
								idx_c = idx_c + IW'(1);
								ym_c  = ys <<< 1;
							end else begin
								ym_c = ys;
							end
						end
					end else begin
						idx_c = nb_s1[nbl_pkg::NB_D] + IW'(1);
						av_c  = av4_s1[nbl_pkg::NB_D];
						ym_c  = ys;
					end
				end else begin
					idx_c = nb_s1[nbl_pkg::NB_A];
					av_c  = av4_s1[nbl_pkg::NB_A];
					if (av_c) begin
						if (!fld) begin
							if (!fl[nbl_pkg::NB_A]) begin
								if (!top) idx_c = idx_c + IW'(1);
								ym_c = ys;
							end else begin
								idx_c = idx_c + IW'(ys[0]);
								ym_c  = top ? (ys >>> 1) : ((ys + mh) >>> 1);
							end
						end else if (!fl[nbl_pkg::NB_A]) begin
							if (ys < (mh >>> 1)) begin
								ym_c = (ys <<< 1) + 10'(!top);
							end else begin
								idx_c = idx_c + IW'(1);
								ym_c  = (ys <<< 1) + 10'(!top) - mh;
							end
						end else begin
							if (!top) idx_c = idx_c + IW'(1);
							ym_c = ys;
						end
					end
				end
			end else if (xs < mw) begin
				if (ys < 0) begin
					if (!fld) begin
						if (top) begin
							idx_c = nb_s1[nbl_pkg::NB_B];
							if (av4_s1[nbl_pkg::NB_B] && !(dbk1 && fl[nbl_pkg::NB_B])) begin
								idx_c = idx_c + IW'(1);
							end
							av_c = av4_s1[nbl_pkg::NB_B];
							ym_c = ys;
						end else begin
							idx_c = cur1 - IW'(1); av_c = 1'b1; ym_c = ys;
						end
					end else if (top) begin
						idx_c = nb_s1[nbl_pkg::NB_B];
						av_c  = av4_s1[nbl_pkg::NB_B];
						if (av_c) begin
							if (!fl[nbl_pkg::NB_B]) begin
								idx_c = idx_c + IW'(1);
								ym_c  = ys <<< 1;
							end else begin
								ym_c = ys;
							end
						end
					end else begin
						idx_c = nb_s1[nbl_pkg::NB_B] + IW'(1);
						av_c  = av4_s1[nbl_pkg::NB_B];
						ym_c  = ys;
					end
				end else if (ys == 0 && dbk2) begin
					idx_c = nb_s1[nbl_pkg::NB_B] + IW'(1); av_c = 1'b1; ym_c = -10'sd1;
				end else begin
					idx_c = cur1; av_c = 1'b1; ym_c = ys;
				end
			end else begin
				if (!fld) begin
					if (top) begin
						idx_c = nb_s1[nbl_pkg::NB_C] + IW'(1);
						av_c  = av4_s1[nbl_pkg::NB_C];
						ym_c  = ys;
					end else begin
						sel_c = 1'b0;
					end
				end else if (top) begin
					idx_c = nb_s1[nbl_pkg::NB_C];
					av_c  = av4_s1[nbl_pkg::NB_C];
					if (av_c) begin
						if (!fl[nbl_pkg::NB_C]) begin
							idx_c = idx_c + IW'(1);
							ym_c  = ys <<< 1;
						end else begin
							ym_c = ys;
						end
					end
				end else begin
					idx_c = nb_s1[nbl_pkg::NB_C] + IW'(1);
					av_c  = av4_s1[nbl_pkg::NB_C];
					ym_c  = ys;
				end
			end
		end
	end

	logic                 vld_s2, sel_s2, av_s2, show_s2;
	logic signed [IW-1:0] idx_s2;
	logic [6:0]           xin_s2, yin_s2;
	logic [2:0]           lw_s2, lh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2  <= sel_c;
			av_s2   <= av_c;
			idx_s2  <= idx_c;
			show_s2 <= av_c || item_s1.deblock_mode != nbl_pkg::DBK_DECODE;
			xin_s2  <= 7'(xs) & 7'(mw - 10'sd1);
			yin_s2  <= 7'(ym_c) & 7'(mh - 10'sd1);
			lw_s2   <= item_s1.block_width_log2;
			lh_s2   <= item_s1.block_height_log2;
		end
	end

	// block position of the selected mb
	nbl_pkg::mid_item_t mid_c;
	logic [15:0]        d2_num;
	logic               d2_valid;
	logic [15:0]        d2_quot;
	logic [DW-1:0]      d2_rem;
	logic [$bits(nbl_pkg::mid_item_t)-1:0] d2_pay;
	nbl_pkg::mid_item_t d2_item;

	always_comb begin
		mid_c.sel     = sel_s2;
		mid_c.av      = av_s2;
		mid_c.idx     = idx_s2[16:0];
		mid_c.show    = show_s2;
		mid_c.in_pic  = !idx_s2[IW-1] && (CW'(idx_s2[IW-2:0]) < CW'(s_q));
		mid_c.idx_lsb = idx_s2[0];
		mid_c.xin     = xin_s2;
		mid_c.yin     = yin_s2;
		mid_c.lw      = lw_s2;
		mid_c.lh      = lh_s2;
	end

	assign d2_num = mbaff_q ? {1'b0, idx_s2[15:1]} : idx_s2[15:0];

	nbl_div #(.NW(16), .DW(DW), .PW($bits(nbl_pkg::mid_item_t))) u_div_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.dividend (d2_num),
		.divisor  (w_q),
		.pay_in   (mid_c),
		.out_valid(d2_valid),
		.quot     (d2_quot),
		.rem      (d2_rem),
		.pay_out  (d2_pay)
	);

	assign d2_item = nbl_pkg::mid_item_t'(d2_pay);

	logic [12:0] bx13, by13, px_c, py_c;

	always_comb begin
		bx13 = 13'(d2_rem);
		by13 = mbaff_q ? 13'({d2_quot, d2_item.idx_lsb}) : 13'(d2_quot);
		px_c = (bx13 << d2_item.lw) + 13'(d2_item.xin);
		py_c = (by13 << d2_item.lh) + 13'(d2_item.yin);
	end

	// output register
	logic signed [16:0] idx_q;
	logic               av_q;
	logic [3:0]         x_q, y_q;
	logic [12:0]        px_q, py_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q <= d2_item.sel ? signed'(d2_item.idx) : '0;
			av_q  <= d2_item.sel && d2_item.av;
			x_q   <= (d2_item.sel && d2_item.show) ? d2_item.xin[3:0] : '0;
			y_q   <= (d2_item.sel && d2_item.show) ? d2_item.yin[3:0] : '0;
			px_q  <= (d2_item.sel && d2_item.show && d2_item.in_pic) ? px_c : '0;
			py_q  <= (d2_item.sel && d2_item.show && d2_item.in_pic) ? py_c : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.nb_mb_index  = idx_q;
	assign out_ch.nb_available = av_q;
	assign out_ch.x_in_mb      = x_q;
	assign out_ch.y_in_mb      = y_q;
	assign out_ch.pos_x        = px_q;
	assign out_ch.pos_y        = py_q;

endmodule
`default_nettype wire

// ----- rtl/nbl_checker.sv -----
`default_nettype none
`include "macroblock_neighbour_locator_top_macros.svh"
module nbl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [16:0] nb_mb_index,
	input wire logic        nb_available,
	input wire logic [12:0] pos_x,
	input wire logic [12:0] pos_y
);

	// whole pipeline moves together with the output register
	`NBL_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "ready mismatch")

	`NBL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(nb_mb_index)
		&& $stable(nb_available) && $stable(pos_x) && $stable(pos_y),
		"output changed under stall")

	`NBL_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "output valid in reset")

endmodule

bind macroblock_neighbour_locator_top nbl_checker u_nbl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.nb_mb_index (out_ch.nb_mb_index),
	.nb_available(out_ch.nb_available),
	.pos_x       (out_ch.pos_x),
	.pos_y       (out_ch.pos_y)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int REG_IDX_W = nbl_pkg::CFG_IDX_W;
	localparam int DATA_W    = nbl_pkg::CFG_DATA_W;
	localparam int IN_W      = $bits(nbl_pkg::in_item_t);
	localparam int NB_A      = nbl_pkg::NB_A;
	localparam int NB_B      = nbl_pkg::NB_B;
	localparam int NB_C      = nbl_pkg::NB_C;
	localparam int NB_D      = nbl_pkg::NB_D;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [DATA_W-1:0] wr_data;

	nbl_in_if in_ch();
	nbl_out_if out_ch();

	macroblock_neighbour_locator_top dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	typedef struct packed {
		logic [16:0] nb_mb_index;
		logic        nb_available;
		logic [3:0]  x_in_mb;
		logic [3:0]  y_in_mb;
		logic [12:0] pos_x;
		logic [12:0] pos_y;
	} nb_loc_t;

	nb_loc_t expected_locs[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	logic [9:0] cfg_width;
	logic [16:0] cfg_size;
	logic cfg_mbaff;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic nb_loc_t locate_neighbour(nbl_pkg::in_item_t r);
		longint cur, xn, yn, mw, mh, w, s, pair, col, coln, idx, ym, bx, by, add;
		longint nb[4];
		bit av4[4], fl[4];
		bit sel, av, fld, top;
		logic [1:0] dbk;
		longint xin, yin;
		nb_loc_t o;
		cur = r.cur_mb_index;
		xn = $signed(r.x_offset);
		yn = $signed(r.y_offset);
		mw = 64'sd1 << r.block_width_log2;
		mh = 64'sd1 << r.block_height_log2;
		fld = r.cur_is_field;
		dbk = r.deblock_mode;
		w = cfg_width;
		s = cfg_size;
		if (w < 1) w = 1;
		if (w > nbl_pkg::MAX_WIDTH_MBS_DEF) w = nbl_pkg::MAX_WIDTH_MBS_DEF;
		if (s > nbl_pkg::MAX_PIC_MBS_DEF) s = nbl_pkg::MAX_PIC_MBS_DEF;
		idx = 0;
		ym = -1;
		sel = 0;
		av = 0;
		if (cfg_mbaff) begin
			pair = cur >>> 1;
			nb[NB_A] = 2 * (pair - 1);
			nb[NB_B] = 2 * (pair - w);
			nb[NB_C] = 2 * (pair - w + 1);
			nb[NB_D] = 2 * (pair - w - 1);
			col = pair % w;
			coln = (pair + 1) % w;
		end else begin
			nb[NB_A] = cur - 1;
			nb[NB_D] = cur - 1 - w;
			nb[NB_B] = nb[NB_D] + 1;
			nb[NB_C] = nb[NB_B] + 1;
			col = cur % w;
			coln = (cur + 1) % w;
		end
		for (int k = 0; k < 4; k++) begin
			av4[k] = nb[k] >= 0 && nb[k] < s &&
				(dbk != nbl_pkg::DBK_DECODE || r.neighbour_same_slice[k]);
			fl[k] = r.neighbour_field[k];
		end
		av4[NB_A] = av4[NB_A] && col != 0;
		av4[NB_D] = av4[NB_D] && col != 0;
		av4[NB_C] = av4[NB_C] && coln != 0;
		top = cur[0] == 1'b0;
		if (!cfg_mbaff) begin
			ym = yn;
			if (xn < 0) begin
				if (yn < 0) begin
					sel = 1; idx = nb[NB_D]; av = av4[NB_D];
				end else if (yn < mh) begin
					sel = 1; idx = nb[NB_A]; av = av4[NB_A];
				end
			end else if (xn < mw) begin
				if (yn < 0) begin
					sel = 1; idx = nb[NB_B]; av = av4[NB_B];
				end else if (yn < mh) begin
					sel = 1; idx = cur; av = 1;
				end
			end else if (yn < 0) begin
				sel = 1; idx = nb[NB_C]; av = av4[NB_C];
			end
		end else if (yn <= mh - 1 && !(xn > mw - 1 && yn >= 0)) begin
			sel = 1;
			if (xn < 0) begin
				if (yn < 0) begin
					if (!fld) begin
						if (top) begin
							idx = nb[NB_D] + 1; av = av4[NB_D]; ym = yn;
						end else begin
							idx = nb[NB_A]; av = av4[NB_A];
							if (av) begin
								if (!fl[NB_A]) ym = yn;
								else begin
									idx++; ym = (yn + mh) >>> 1;
								end
							end
						end
					end else if (top) begin
						idx = nb[NB_D]; av = av4[NB_D];
						if (av) begin
							if (!fl[NB_D]) begin
								idx++; ym = 2 * yn;
							end else ym = yn;
						end
					end else begin
						idx = nb[NB_D] + 1; av = av4[NB_D]; ym = yn;
					end
				end else begin
					idx = nb[NB_A]; av = av4[NB_A];
					if (av) begin
						if (!fld) begin
							if (!fl[NB_A]) begin
								if (!top) idx++;
								ym = yn;
							end else begin
								idx += yn & 1;
								ym = top ? (yn >>> 1) : ((yn + mh) >>> 1);
							end
						end else if (!fl[NB_A]) begin
							add = top ? 0 : 1;
							if (yn < (mh >>> 1)) ym = 2 * yn + add;
							else begin
								idx++; ym = 2 * yn + add - mh;
							end
						end else begin
							if (!top) idx++;
							ym = yn;
						end
					end
				end
			end else if (xn < mw) begin
				if (yn < 0) begin
					if (!fld) begin
						if (top) begin
							idx = nb[NB_B];
							if (av4[NB_B] && !(dbk == nbl_pkg::DBK_FILTER && fl[NB_B])) idx++;
							av = av4[NB_B]; ym = yn;
						end else begin
							idx = cur - 1; av = 1; ym = yn;
						end
					end else if (top) begin
						idx = nb[NB_B]; av = av4[NB_B];
						if (av) begin
							if (!fl[NB_B]) begin
								idx++; ym = 2 * yn;
							end else ym = yn;
						end
					end else begin
						idx = nb[NB_B] + 1; av = av4[NB_B]; ym = yn;
					end
				end else if (yn == 0 && dbk == nbl_pkg::DBK_FILTER_TOP) begin
					idx = nb[NB_B] + 1; av = 1; ym = -1;
				end else begin
					idx = cur; av = 1; ym = yn;
				end
			end else begin
				if (!fld) begin
					if (top) begin
						idx = nb[NB_C] + 1; av = av4[NB_C]; ym = yn;
					end else sel = 0;
				end else if (top) begin
					idx = nb[NB_C]; av = av4[NB_C];
					if (av) begin
						if (!fl[NB_C]) begin
							idx++; ym = 2 * yn;
						end else ym = yn;
					end
				end else begin
					idx = nb[NB_C] + 1; av = av4[NB_C]; ym = yn;
				end
			end
		end
		o = '0;
		if (sel) begin
			o.nb_mb_index = idx[16:0];
			o.nb_available = av;
			if (av || dbk != nbl_pkg::DBK_DECODE) begin
				xin = xn & (mw - 1);
				yin = ym & (mh - 1);
				o.x_in_mb = xin[3:0];
				o.y_in_mb = yin[3:0];
				if (idx >= 0 && idx < s) begin
					if (cfg_mbaff) begin
						pair = idx >>> 1;
						bx = pair % w;
						by = 2 * (pair / w) + (idx & 1);
					end else begin
						bx = idx % w;
						by = idx / w;
					end
					bx = bx * mw + xin;
					by = by * mh + yin;
					o.pos_x = bx[12:0];
					o.pos_y = by[12:0];
				end
			end
		end
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		nb_loc_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = {out_ch.nb_mb_index, out_ch.nb_available, out_ch.x_in_mb,
				out_ch.y_in_mb, out_ch.pos_x, out_ch.pos_y};
			if (expected_locs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h", got);
			end else begin
				want = expected_locs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp idx %0h av %0b x %0d y %0d px %0d py %0d,",
							" got idx %0h av %0b x %0d y %0d px %0d py %0d"},
							want.nb_mb_index, want.nb_available, want.x_in_mb,
							want.y_in_mb, want.pos_x, want.pos_y, got.nb_mb_index,
							got.nb_available, got.x_in_mb, got.y_in_mb, got.pos_x,
							got.pos_y);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(nbl_pkg::in_item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.cur_mb_index, in_ch.x_offset, in_ch.y_offset, in_ch.block_width_log2,
			in_ch.block_height_log2, in_ch.cur_is_field, in_ch.deblock_mode,
			in_ch.neighbour_same_slice, in_ch.neighbour_field} <= r;
		do @(posedge clk); while (!in_ch.ready);
		expected_locs.push_back(locate_neighbour(r));
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_locs.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		case (idx)
			nbl_pkg::REG_PIC_WIDTH: cfg_width = val[9:0];
			nbl_pkg::REG_PIC_SIZE: cfg_size = val;
			nbl_pkg::REG_MBAFF: cfg_mbaff = val[0];
			default: ;
		endcase
	endtask

	task automatic set_picture(int w, int s, bit mbaff);
		drain();
		write_reg(nbl_pkg::REG_PIC_WIDTH, DATA_W'(w));
		write_reg(nbl_pkg::REG_PIC_SIZE, DATA_W'(s));
		write_reg(nbl_pkg::REG_MBAFF, DATA_W'(mbaff));
		wr_en <= 1'b0;
	endtask

	function automatic nbl_pkg::in_item_t random_request(int s);
		nbl_pkg::in_item_t r;
		r = IN_W'({$urandom, $urandom});
		r.cur_mb_index = ($urandom_range(9) == 0) ? 16'($urandom)
			: 16'($urandom_range(s > 0 ? s : 1));
		r.x_offset = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(17) - 1);
		r.y_offset = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(17) - 1);
		r.block_width_log2 = ($urandom_range(9) == 0) ? 3'($urandom)
			: 3'($urandom_range(4, 3));
		r.block_height_log2 = ($urandom_range(9) == 0) ? 3'($urandom)
			: 3'($urandom_range(4, 3));
		return r;
	endfunction

	task automatic test_directed();
		nbl_pkg::in_item_t r;
		int offs[6] = '{-1, 0, 7, 15, 16, 31};
		set_picture(4, 32, 1'b0);
		for (int i = 0; i < 6; i++) begin
			r = '0;
			r.cur_mb_index = 16'(5 + i);
			r.x_offset = 6'(offs[i]);
			r.y_offset = 6'(offs[5 - i]);
			r.block_width_log2 = 3'd4;
			r.block_height_log2 = 3'd4;
			r.deblock_mode = 2'(i % 4);
			r.neighbour_same_slice = 4'hf;
			send_request(r);
		end
		set_picture(3, 24, 1'b1);
		for (int i = 0; i < 16; i++) begin
			r = '0;
			r.cur_mb_index = 16'(8 + (i & 1));
			r.x_offset = 6'(offs[i % 6]);
			r.y_offset = (i < 8) ? 6'h3f : 6'(i);
			r.block_width_log2 = 3'd4;
			r.block_height_log2 = ((i & 2) != 0) ? 3'd3 : 3'd4;
			r.cur_is_field = i[2];
			r.deblock_mode = ((i & 3) == 3) ? nbl_pkg::DBK_FILTER_TOP : nbl_pkg::DBK_FILTER;
			r.neighbour_same_slice = 4'hf;
			r.neighbour_field = i[3] ? 4'hf : 4'h0;
			send_request(r);
		end
		r = '1;
		send_request(r);
	endtask

	task automatic test_random(int n);
		int ws[4] = '{1, 512, 0, 1023};
		int ss[4] = '{1, 65536, 131071, 0};
		int w, s;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 4) begin
				w = ws[ph];
				s = ss[ph];
			end else begin
				w = int'($urandom_range(20, 1));
				s = w * int'($urandom_range(12, 1));
			end
			set_picture(w, s, ph[0]);
			for (int i = 0; i < n; i++) send_request(random_request(s > 70000 ? 65535 : s));
			if (ph == 2) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		{in_ch.cur_mb_index, in_ch.x_offset, in_ch.y_offset, in_ch.block_width_log2,
			in_ch.block_height_log2, in_ch.cur_is_field, in_ch.deblock_mode,
			in_ch.neighbour_same_slice, in_ch.neighbour_field} = '0;
		out_ch.ready = 1'b0;
		cfg_width = 1;
		cfg_size = 1;
		cfg_mbaff = 0;
		mismatches = 0;
		send_idle_pct = 8;
		recv_idle_pct = 82;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(70);
		send_idle_pct = 82;
		recv_idle_pct = 8;
		test_random(70);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(70);
		drain();
		if (mismatches == 0 && expected_locs.size() == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
